### design/signed_int_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_defines.svh
// assertion macros shared by the converter modules
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent holds -> consequent holds in the same cycle
`define S2D_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s2d assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define S2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("s2d assertion failed");

`else

`define S2D_ASSERT_SAME(label, clk, rst, ante, cons)
`define S2D_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// widths, character codes and handoff type of the decimal text converter
// ----------------------------------------------------------------------------
package s2d_pkg;

   localparam int VALUE_BITS = 32;
   // decimal digits of 2^(VALUE_BITS-1), log10(2) ~ 0.30103
   localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_BITS   = 4 * DIGITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam int LEFT_BITS  = $clog2(DIGITS + 1);
   localparam int CHAR_BITS  = 6;
   localparam int DATA_BITS  = 8;

   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 6'd45;

   // finished bcd digits plus sign, converter to emitter
   typedef struct packed {
      logic [BCD_BITS-1:0] bcd;
      logic                neg;
   } handoff_type;

endpackage

### design/s2d_dabble.sv
// ----------------------------------------------------------------------------
// s2d_dabble
// bit-serial double dabble: magnitude in, packed bcd digits out
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module s2d_dabble (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [s2d_pkg::VALUE_BITS-1:0]   mag,
   input  logic                             neg,
   output logic                             idle,
   output logic                             hand_valid,
   input  logic                             hand_ready,
   output s2d_pkg::handoff_type             hand
);
   import s2d_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_DONE} state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic                  digits_ok;

   // add three to every digit of five or more, digits are independent
   always_comb begin
      logic [3:0] d;
      digits_ok = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
         if (d > 4'd9) digits_ok = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in   = mag;
               bcd_in   = '0;
               cnt_in   = '0;
               neg_in   = neg;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (hand_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign hand_valid = (state_ff == ST_DONE);
   assign hand.bcd   = bcd_ff;
   assign hand.neg   = neg_ff;

   `S2D_ASSERT_NEXT(a_start_shift, clock, reset, start && idle,
      state_ff == ST_SHIFT && cnt_ff == '0)
   `S2D_ASSERT_NEXT(a_shift_ends, clock, reset,
      state_ff == ST_SHIFT && cnt_ff == CNT_BITS'(VALUE_BITS - 1), state_ff == ST_DONE)
   `S2D_ASSERT_SAME(a_digits_valid, clock, reset, state_ff == ST_DONE, digits_ok)
   `S2D_ASSERT_NEXT(a_hand_holds, clock, reset, hand_valid && !hand_ready,
      hand_valid && $stable(bcd_ff) && $stable(neg_ff))

endmodule

### design/s2d_emit.sv
// ----------------------------------------------------------------------------
// s2d_emit
// digit serializer: drops leading zeros, emits sign and digits as ascii
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module s2d_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            hand_valid,
   output logic                            hand_ready,
   input  s2d_pkg::handoff_type            hand,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [s2d_pkg::CHAR_BITS-1:0]   rsp_char,
   output logic                            rsp_last
);
   import s2d_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 started_ff, started_in;
   logic                 neg_ff, neg_in;
   logic [BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic [LEFT_BITS-1:0] left_ff, left_in;
   logic                 valid_ff, valid_in;
   logic [CHAR_BITS-1:0] char_ff, char_in;
   logic                 last_ff, last_in;
   logic [3:0]           top;
   logic                 out_free;
   logic                 skip;
   logic                 emit_digit;

   assign top        = bcd_ff[BCD_BITS-1 -: 4];
   assign out_free   = !valid_ff || rsp_tready;
   assign skip       = busy_ff && !started_ff && (left_ff > LEFT_BITS'(1)) && (top == 4'd0);
   assign emit_digit = busy_ff && !skip && out_free && !neg_ff;
   assign hand_ready = !busy_ff;

   always_comb begin
      busy_in    = busy_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      bcd_in     = bcd_ff;
      left_in    = left_ff;
      valid_in   = valid_ff && !rsp_tready;
      char_in    = char_ff;
      last_in    = last_ff;
      if (!busy_ff) begin
         if (hand_valid) begin
            busy_in    = 1'b1;
            started_in = 1'b0;
            neg_in     = hand.neg;
            bcd_in     = hand.bcd;
            left_in    = LEFT_BITS'(DIGITS);
         end
      end else if (skip) begin
         // leading zero, no output
         bcd_in  = {bcd_ff[BCD_BITS-5:0], 4'd0};
         left_in = left_ff - LEFT_BITS'(1);
      end else if (out_free) begin
         valid_in = 1'b1;
         if (neg_ff) begin
            char_in = CH_MINUS;
            last_in = 1'b0;
            neg_in  = 1'b0;
         end else begin
            char_in    = CH_ZERO + CHAR_BITS'(top);
            last_in    = (left_ff == LEFT_BITS'(1));
            started_in = 1'b1;
            bcd_in     = {bcd_ff[BCD_BITS-5:0], 4'd0};
            left_in    = left_ff - LEFT_BITS'(1);
            if (left_ff == LEFT_BITS'(1)) busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      started_ff <= started_in;
      neg_ff     <= neg_in;
      bcd_ff     <= bcd_in;
      left_ff    <= left_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_char   = char_ff;
   assign rsp_last   = last_ff;

   `S2D_ASSERT_SAME(a_left_nonzero, clock, reset, busy_ff, left_ff != '0)
   `S2D_ASSERT_NEXT(a_last_frees, clock, reset,
      emit_digit && left_ff == LEFT_BITS'(1), !busy_ff && rsp_last)
   `S2D_ASSERT_SAME(a_minus_not_last, clock, reset,
      rsp_tvalid && rsp_char == CH_MINUS, !rsp_last)
   `S2D_ASSERT_NEXT(a_skip_silent, clock, reset, skip && !rsp_tvalid, !rsp_tvalid)

endmodule

### design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per word
// ----------------------------------------------------------------------------
// usage:
//  - req channel takes one two's complement integer per word in req_tdata
//  - rsp channel returns its decimal text, most significant character first:
//    a '-' for negative values, then the digits without leading zeros;
//    rsp_tlast marks the final character, zero gives the single word '0'
//  - the most negative value prints as -2147483648 (unsigned magnitude)
//  - the first character follows acceptance after the 32 one-bit-per-cycle
//    double dabble steps and one leading-zero drop per missing digit, then
//    one character per cycle while the receiver is ready
//  - the bit-serial converter takes a new value only after load, 32 shift
//    steps and handoff; the emitter works on the previous value meanwhile,
//    so values of up to 11 characters do not slow the input side down while
//    the receiver does not stall
//  - reset clears the converter and emitter control; nothing is kept
//    between values
//  - a stalled receiver holds the current character in the output register;
//    the converter still finishes the next value and waits to hand it over
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: value [31:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic signed [s2d_pkg::VALUE_BITS-1:0] req_tdata,
   // rsp_tdata: char_code [5:0], zero pad [7:6]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [s2d_pkg::DATA_BITS-1:0]        rsp_tdata,
   output logic                                 rsp_tlast
);
   import s2d_pkg::*;

   logic                  req_accept;
   logic                  neg;
   logic [VALUE_BITS-1:0] mag;
   logic                  conv_idle;
   logic                  hand_valid;
   logic                  hand_ready;
   handoff_type           hand;
   logic [CHAR_BITS-1:0]  rsp_char;

   // converter takes a new word only when idle: not shifting, not waiting to hand over
   assign req_tready = conv_idle;
   assign req_accept = req_tvalid && req_tready;

   // magnitude; the most negative value wraps onto its own unsigned magnitude
   assign neg = req_tdata[VALUE_BITS-1];
   assign mag = neg ? (~req_tdata + VALUE_BITS'(1)) : req_tdata;

   // bit-serial binary to bcd
   s2d_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .mag        (mag),
      .neg        (neg),
      .idle       (conv_idle),
      .hand_valid (hand_valid),
      .hand_ready (hand_ready),
      .hand       (hand)
   );

   // bcd to character words, output register on the rsp side
   s2d_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .hand_valid (hand_valid),
      .hand_ready (hand_ready),
      .hand       (hand),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   // character code in the low bits, zero fill to a whole byte
   assign rsp_tdata = {(DATA_BITS - CHAR_BITS)'(0), rsp_char};

endmodule

### tb/sv/tb_signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// self-checking bench for the signed integer to decimal ascii converter
// ----------------------------------------------------------------------------
// a directed table covers zero, single digits, powers of ten and both ends of
// the 32-bit range, then a few hundred random values follow, biased toward
// small numbers, digit-count boundaries and the range ends. random values and
// directed rows without typed text are spelled by a local decimal speller;
// each character word that comes back is compared against the oldest waiting
// character. both sides insert random gaps, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
   import s2d_pkg::*;

   localparam int RANDOM_VALUES = 470;
   localparam int MAX_GAP       = 18;
   localparam int DRAIN_CYCLES  = 60;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // one expected character word
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last_char;
   } text_char_type;

   // directed row: empty text means the speller supplies the characters
   typedef struct {
      value_type value;
      string     text;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   value_type            req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;

   text_char_type pending_chars[$];
   int            error_count;
   bit            tx_quiet;
   bit            rx_quiet;

   dir_row_type dir_rows [19] = '{
      '{32'sd0,           "0"},
      '{32'sd1,           "1"},
      '{-32'sd1,          "-1"},
      '{32'sd9,           "9"},
      '{32'sd10,          "10"},
      '{-32'sd10,         "-10"},
      '{32'sd2147483647,  "2147483647"},
      '{32'h8000_0000,    "-2147483648"},
      '{-32'sd2147483647, "-2147483647"},
      '{32'sd1000000000,  "1000000000"},
      '{-32'sd999999999,  ""},
      '{32'hAAAA_AAAA,    ""},
      '{32'h5555_5555,    ""},
      '{32'sd12345,       ""},
      '{-32'sd67890,      ""},
      '{32'sd99,          ""},
      '{32'hFFFF_FF00,    ""},
      '{32'h0000_FFFF,    ""},
      '{32'sd100,         ""}
   };

   signed_int_to_decimal_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // generous cap: every value at full length with every gap at its worst
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic note_error(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // decimal text of a two's complement value, sign first, no leading zeros
   function automatic void predict_text(input value_type word);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digs [DIGITS];
      int                    n;
      n   = 0;
      mag = word[VALUE_BITS-1] ? (~word + 1'b1) : word;
      // magnitude of the most negative value fits as unsigned
      do begin
         digs[n] = 4'(mag % 10);
         mag     = mag / 10;
         n++;
      end while (mag != 0);
      if (word[VALUE_BITS-1])
         pending_chars.push_back(text_char_type'{char_code: CH_MINUS, last_char: 1'b0});
      for (int i = n - 1; i >= 0; i--)
         pending_chars.push_back(text_char_type'{char_code: CH_ZERO + CHAR_BITS'(digs[i]),
                                                 last_char: (i == 0)});
   endfunction

   // typed-in characters of a directed row
   function automatic void spell_text(input string text);
      byte c;
      for (int i = 0; i < text.len(); i++) begin
         c = text[i];
         pending_chars.push_back(text_char_type'{char_code: c[CHAR_BITS-1:0],
                                                 last_char: (i == text.len() - 1)});
      end
   endfunction

   // one value across the req channel; returns at the accepting edge
   task automatic send_value(input value_type word);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // random values leaning on digit-count and range boundaries
   function automatic value_type draw_value();
      logic [VALUE_BITS-1:0] p;
      value_type             v;
      p = 1;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 99);
         1: begin
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p + $urandom_range(0, 2) - 1;
         end
         2: v = 32'h8000_0000 + $urandom_range(0, 3);
         3: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
         4: v = $urandom >> $urandom_range(0, 31);
         default: v = $urandom;
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // receiver: random stalls, checks every accepted character word
   initial begin : rsp_side
      text_char_type want;
      int            gap;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               note_error($sformatf("unexpected word 0x%02h last %0b", rsp_tdata, rsp_tlast));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata[CHAR_BITS-1:0] !== want.char_code)
                  note_error($sformatf("char_code %0d, expected %0d",
                                       rsp_tdata[CHAR_BITS-1:0], want.char_code));
               if (rsp_tdata[DATA_BITS-1:CHAR_BITS] !== '0)
                  note_error($sformatf("pad bits %b not zero",
                                       rsp_tdata[DATA_BITS-1:CHAR_BITS]));
               if (rsp_tlast !== want.last_char)
                  note_error($sformatf("tlast %b, expected %b", rsp_tlast, want.last_char));
            end
            gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // reset, directed table, random values, drain
   initial begin : req_side
      value_type v;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      error_count = 0;
      tx_quiet    = 1'b0;
      rx_quiet    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_value(dir_rows[i].value);
         if (dir_rows[i].text.len() > 0)
            spell_text(dir_rows[i].text);
         else
            predict_text(dir_rows[i].value);
      end

      for (int n = 0; n < RANDOM_VALUES; n++) begin
         // switch gap behavior now and then so back-to-back runs happen too
         if (n % 40 == 0) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
         end
         v = draw_value();
         send_value(v);
         predict_text(v);
      end
      req_tvalid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
